>>> hdl/sct_pkg.sv
// shared types and constants of the store coverage tracker
// no dependencies; imported by every module of the block
package sct_pkg;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } sct_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_READ,
        ST_EVAL,
        ST_EVAL2,
        ST_TAIL,
        ST_COMMIT,
        ST_OUT
    } sct_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic lookup;
        logic set_full;
        logic rd;
        logic eval;
        logic wr_pend;
        logic tail;
        logic commit;
    } sct_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_clear;
        logic is_nop;
        logic full_miss;
        logic empty;
        logic is_store;
        logic second;
        logic last;
    } sct_status_t;

    localparam int TDATA_IN_W  = 56;
    localparam int TDATA_OUT_W = 8;
    localparam int POS_W       = 33;

endpackage

>>> hdl/sct_ctrl.sv
// sequencer of the store coverage tracker
// depends on sct_pkg; drives the datapath sct_dp through command structs
module sct_ctrl
    import sct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  sct_status_t status,
    output sct_cmd_t    cmd
);

    sct_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (status.is_clear)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_OUT;
                end
                else if (status.is_nop)
                begin
                    state_next = ST_OUT;
                end
                else if (status.full_miss)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.lookup = 1'b1;
                    if (!status.empty)
                        state_next = ST_READ;
                    else if (status.is_store)
                        state_next = ST_TAIL;
                    else
                        state_next = ST_COMMIT;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.second)
                    state_next = ST_EVAL2;
                else if (!status.last)
                    state_next = ST_READ;
                else if (status.is_store)
                    state_next = ST_TAIL;
                else
                    state_next = ST_COMMIT;
            end
            ST_EVAL2:
            begin
                cmd.wr_pend = 1'b1;
                if (!status.last)
                    state_next = ST_READ;
                else if (status.is_store)
                    state_next = ST_TAIL;
                else
                    state_next = ST_COMMIT;
            end
            ST_TAIL:
            begin
                cmd.tail   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/sct_dp.sv
// datapath of the store coverage tracker: slot table, interval memory, merge and punch
// depends on sct_pkg; sequenced by sct_ctrl
module sct_dp
    import sct_pkg::*;
#(
    parameter int BASE_SLOTS    = 8,
    parameter int MAX_INTERVALS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    input  logic [1:0]             s_tuser,
    input  sct_cmd_t               cmd,
    output sct_status_t            status,
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    localparam int SW    = (BASE_SLOTS > 1) ? $clog2(BASE_SLOTS) : 1;
    localparam int IW    = $clog2(MAX_INTERVALS);
    localparam int CW    = $clog2(MAX_INTERVALS + 1);
    localparam int WW    = $clog2(MAX_INTERVALS + 3);
    localparam int DEPTH = 2 * BASE_SLOTS * MAX_INTERVALS;
    localparam int AW    = $clog2(DEPTH);

    // slot table
    logic [7:0]    tag_tab_reg   [BASE_SLOTS];
    logic          valid_tab_reg [BASE_SLOTS];
    logic [CW-1:0] count_tab_reg [BASE_SLOTS];
    logic          bank_tab_reg  [BASE_SLOTS];

    // interval memory, two banks per slot so a pass reads one and writes the other
    logic signed [POS_W-1:0] mem_start [DEPTH];
    logic signed [POS_W-1:0] mem_end   [DEPTH];
    logic signed [POS_W-1:0] ra_reg, rb_reg;

    // current event
    sct_op_t                 op_reg;
    logic [7:0]              tag_reg;
    logic signed [POS_W-1:0] s_reg, e_reg, ms_reg, me_reg;
    logic signed [POS_W-1:0] pa_reg, pb_reg;
    logic                    wzero_reg;
    logic [SW-1:0]           slot_reg;
    logic [CW-1:0]           n_reg;
    logic [IW-1:0]           rd_reg;
    logic [WW-1:0]           wr_reg;
    logic                    placed_reg, covered_reg;
    logic                    dead_reg, drop_reg;

    logic                    hit, free;
    logic [SW-1:0]           hit_idx, free_idx, sel_slot;
    logic [CW-1:0]           lk_count;

    logic                    p0_v, p1_v, placed_next, covered_next;
    logic signed [POS_W-1:0] p0_a, p0_b, p1_a, p1_b, ms_next, me_next;

    logic                    wen;
    logic signed [POS_W-1:0] w_a, w_b;
    logic [AW-1:0]           waddr, raddr;

    always_comb
    begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = BASE_SLOTS - 1; i >= 0; i--)
        begin
            if (valid_tab_reg[i] && tag_tab_reg[i] == tag_reg)
            begin
                hit     = 1'b1;
                hit_idx = SW'(i);
            end
            if (!valid_tab_reg[i])
            begin
                free     = 1'b1;
                free_idx = SW'(i);
            end
        end
        sel_slot = hit ? hit_idx : free_idx;
        lk_count = hit ? count_tab_reg[hit_idx] : '0;
    end

    // one stored interval against the access, up to two output pushes
    always_comb
    begin
        p0_v         = 1'b0;
        p1_v         = 1'b0;
        p0_a         = ra_reg;
        p0_b         = rb_reg;
        p1_a         = ra_reg;
        p1_b         = rb_reg;
        ms_next      = ms_reg;
        me_next      = me_reg;
        placed_next  = placed_reg;
        covered_next = covered_reg;
        if (op_reg == CMD_STORE)
        begin
            if (ra_reg <= s_reg && e_reg <= rb_reg)
                covered_next = 1'b1;
            if (placed_reg || rb_reg < ms_reg)
            begin
                p0_v = 1'b1;
            end
            else if (ra_reg > me_reg)
            begin
                p0_v        = 1'b1;
                p0_a        = ms_reg;
                p0_b        = me_reg;
                p1_v        = 1'b1;
                placed_next = 1'b1;
            end
            else
            begin
                if (ra_reg < ms_reg)
                    ms_next = ra_reg;
                if (rb_reg > me_reg)
                    me_next = rb_reg;
            end
        end
        else
        begin
            if (rb_reg <= s_reg || ra_reg >= e_reg)
            begin
                p0_v = 1'b1;
            end
            else if (ra_reg < s_reg)
            begin
                p0_v = 1'b1;
                p0_b = s_reg;
                p1_v = rb_reg > e_reg;
                p1_a = e_reg;
            end
            else if (rb_reg > e_reg)
            begin
                p0_v = 1'b1;
                p0_a = e_reg;
            end
        end
    end

    always_comb
    begin
        wen = 1'b0;
        w_a = p0_a;
        w_b = p0_b;
        if (cmd.eval && p0_v)
        begin
            wen = 1'b1;
        end
        else if (cmd.wr_pend)
        begin
            wen = 1'b1;
            w_a = pa_reg;
            w_b = pb_reg;
        end
        else if (cmd.tail && !placed_reg)
        begin
            wen = 1'b1;
            w_a = ms_reg;
            w_b = me_reg;
        end
    end

    assign raddr = AW'((32'(bank_tab_reg[slot_reg]) * BASE_SLOTS + 32'(slot_reg))
                       * MAX_INTERVALS + 32'(rd_reg));
    assign waddr = AW'((32'(!bank_tab_reg[slot_reg]) * BASE_SLOTS + 32'(slot_reg))
                       * MAX_INTERVALS + 32'(wr_reg[IW-1:0]));

    always_ff @(posedge clk)
    begin
        if (wen && wr_reg < WW'(MAX_INTERVALS))
        begin
            mem_start[waddr] <= w_a;
            mem_end[waddr]   <= w_b;
        end
        if (cmd.rd)
        begin
            ra_reg <= mem_start[raddr];
            rb_reg <= mem_end[raddr];
        end
    end

    // event registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= sct_op_t'(s_tuser);
            tag_reg   <= s_tdata[7:0];
            s_reg     <= POS_W'($signed(s_tdata[39:8]));
            e_reg     <= POS_W'($signed(s_tdata[39:8])) + $signed({17'd0, s_tdata[55:40]});
            wzero_reg <= s_tdata[55:40] == 16'd0;
        end
        if (cmd.lookup)
        begin
            slot_reg <= sel_slot;
            n_reg    <= lk_count;
            ms_reg   <= s_reg;
            me_reg   <= e_reg;
        end
        else if (cmd.eval)
        begin
            ms_reg <= ms_next;
            me_reg <= me_next;
        end
        if (cmd.eval)
        begin
            pa_reg <= p1_a;
            pb_reg <= p1_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BASE_SLOTS; i++)
            begin
                tag_tab_reg[i]   <= '0;
                valid_tab_reg[i] <= 1'b0;
                count_tab_reg[i] <= '0;
                bank_tab_reg[i]  <= 1'b0;
            end
            rd_reg      <= '0;
            wr_reg      <= '0;
            placed_reg  <= 1'b0;
            covered_reg <= 1'b0;
            dead_reg    <= 1'b0;
            drop_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                dead_reg <= 1'b0;
                drop_reg <= 1'b0;
            end
            if (cmd.set_full)
                drop_reg <= 1'b1;
            if (cmd.clear)
            begin
                for (int i = 0; i < BASE_SLOTS; i++)
                begin
                    valid_tab_reg[i] <= 1'b0;
                    count_tab_reg[i] <= '0;
                end
            end
            if (cmd.lookup)
            begin
                rd_reg      <= '0;
                wr_reg      <= '0;
                placed_reg  <= 1'b0;
                covered_reg <= 1'b0;
                if (op_reg == CMD_STORE && !hit)
                begin
                    valid_tab_reg[sel_slot] <= 1'b1;
                    tag_tab_reg[sel_slot]   <= tag_reg;
                    count_tab_reg[sel_slot] <= '0;
                end
            end
            if (cmd.eval)
            begin
                placed_reg  <= placed_next;
                covered_reg <= covered_next;
                if (!p1_v)
                    rd_reg <= rd_reg + 1'b1;
            end
            if (cmd.wr_pend)
                rd_reg <= rd_reg + 1'b1;
            if (wen)
                wr_reg <= wr_reg + 1'b1;
            if (cmd.commit)
            begin
                // overflow drops the highest intervals
                if (wr_reg > WW'(MAX_INTERVALS))
                begin
                    count_tab_reg[slot_reg] <= CW'(MAX_INTERVALS);
                    drop_reg                <= 1'b1;
                end
                else
                begin
                    count_tab_reg[slot_reg] <= CW'(wr_reg);
                end
                bank_tab_reg[slot_reg] <= !bank_tab_reg[slot_reg];
                dead_reg               <= covered_reg;
            end
        end
    end

    always_comb
    begin
        status.is_clear  = op_reg == CMD_CLEAR;
        status.is_nop    = op_reg == CMD_NONE || wzero_reg || (op_reg == CMD_LOAD && !hit);
        status.full_miss = op_reg == CMD_STORE && !hit && !free;
        status.empty     = lk_count == '0;
        status.is_store  = op_reg == CMD_STORE;
        status.second    = p1_v;
        status.last      = CW'(rd_reg) + CW'(1) == n_reg;
    end

    assign m_tdata = {6'd0, drop_reg, dead_reg};

endmodule

>>> hdl/store_coverage_tracker.sv
// top level of the store coverage tracker
// depends on sct_pkg, sct_ctrl and sct_dp
//
// Events come in on the s_ channel in reverse program order: store, load or
// clear-all, each with a base tag, a signed byte offset and a byte width.
// One result beat per event leaves on the m_ channel: store_dead says that
// later stores fully covered the store, coverage_dropped that the interval
// list of a base overflowed or that no base slot was free.
// One event is handled at a time; s_tready is high only while idle, so the
// next event is taken in the cycle after the result beat is accepted.
// Clear-all, ignored events and a store that finds no free slot go from the
// lookup straight to the result beat. Otherwise the base's interval list is
// walked, one memory read per interval, with an extra step when one interval
// splits around a load or is shifted behind a newly placed store range, then
// a tail step for a store and a commit step before the result beat.
// At reset all base slots are free and the interval memory needs no clearing.
// While m_tready is low the result holds and no new event is taken.
module store_coverage_tracker
    import sct_pkg::*;
#(
    parameter int BASE_SLOTS    = 8,
    parameter int MAX_INTERVALS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,  // base_tag, start_offset, byte_width
    input  logic [1:0]             s_tuser,  // command
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata   // store_dead, coverage_dropped, zero pad
);

    sct_cmd_t    cmd;
    sct_status_t status;

    sct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sct_dp #(
        .BASE_SLOTS    (BASE_SLOTS),
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata)
    );

endmodule

>>> hdl/sct_checker.sv
// port level checks of the store coverage tracker, bound to the top level
// depends on sct_pkg for the port widths
module sct_checker
    import sct_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one event at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("no busy cycle after an accepted beat");

    // merging a covered range never grows the list
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> !m_tdata[1] && m_tdata[7:2] == 6'd0)
        else $error("dead store reported with dropped coverage");

endmodule

bind store_coverage_tracker sct_checker u_sct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/tb_top.sv
// testbench for store_coverage_tracker: random and directed memory events
// depends on sct_pkg and the store_coverage_tracker rtl
module tb_top;
    import sct_pkg::*;

    localparam int SLOTS = 8;
    localparam int MAXIV = 16;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  tag;
        logic [31:0] offs;
        logic [15:0] width;
    } event_t;

    typedef struct packed {
        logic dead;
        logic dropped;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [TDATA_IN_W-1:0] s_tdata;
    logic [1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;

    store_coverage_tracker uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor state
    logic [7:0]  slot_tag_q [SLOTS];
    logic        slot_used_q [SLOTS];
    longint      iv_lo [SLOTS][MAXIV];
    longint      iv_hi [SLOTS][MAXIV];
    int          iv_cnt [SLOTS];
    longint      work_lo [$];
    longint      work_hi [$];

    event_t   pending_events [$];
    verdict_t expected_verdicts [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int errors;
    int accepted_events;
    int checked_verdicts;
    int dead_seen;
    int drop_seen;
    int quiet_cycles;
    bit stim_done;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int find_slot(logic [7:0] tag);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used_q[i] && slot_tag_q[i] == tag)
                return i;
        return -1;
    endfunction

    // append one interval to the work list
    function automatic void add_piece(longint a, longint b);
        work_lo.insert(work_lo.size(), a);
        work_hi.insert(work_hi.size(), b);
    endfunction

    function automatic void queue_event(event_t ev);
        pending_events.insert(pending_events.size(), ev);
    endfunction

    function automatic bit write_back(int sl);
        int n;
        bit dropped;
        n = work_lo.size();
        dropped = 0;
        if (n > MAXIV)
        begin
            n = MAXIV;
            dropped = 1;
        end
        for (int i = 0; i < n; i++)
        begin
            iv_lo[sl][i] = work_lo[i];
            iv_hi[sl][i] = work_hi[i];
        end
        iv_cnt[sl] = n;
        return dropped;
    endfunction

    function automatic verdict_t predict_verdict(event_t ev);
        verdict_t v;
        longint s;
        longint e;
        longint a;
        longint b;
        int sl;
        bit placed;
        v = '0;
        s = longint'($signed(ev.offs));
        e = s + longint'(ev.width);
        work_lo.delete();
        work_hi.delete();
        if (ev.op == CMD_CLEAR)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_used_q[i] = 0;
                iv_cnt[i] = 0;
            end
        end
        else if (ev.op == CMD_LOAD && ev.width != 0)
        begin
            sl = find_slot(ev.tag);
            if (sl >= 0)
            begin
                for (int i = 0; i < iv_cnt[sl]; i++)
                begin
                    a = iv_lo[sl][i];
                    b = iv_hi[sl][i];
                    if (b <= s || a >= e)
                    begin
                        add_piece(a, b);
                    end
                    else
                    begin
                        if (a < s)
                            add_piece(a, s);
                        if (b > e)
                            add_piece(e, b);
                    end
                end
                v.dropped = write_back(sl);
            end
        end
        else if (ev.op == CMD_STORE && ev.width != 0)
        begin
            sl = find_slot(ev.tag);
            if (sl < 0)
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (sl < 0 && !slot_used_q[i])
                    begin
                        sl = i;
                        slot_used_q[i] = 1;
                        slot_tag_q[i] = ev.tag;
                        iv_cnt[i] = 0;
                    end
            end
            if (sl < 0)
                v.dropped = 1;
            else
            begin
                for (int i = 0; i < iv_cnt[sl]; i++)
                begin
                    if (iv_lo[sl][i] > s)
                        break;
                    if (e <= iv_hi[sl][i])
                    begin
                        v.dead = 1;
                        break;
                    end
                end
                placed = 0;
                for (int i = 0; i < iv_cnt[sl]; i++)
                begin
                    a = iv_lo[sl][i];
                    b = iv_hi[sl][i];
                    if (placed || b < s)
                    begin
                        add_piece(a, b);
                    end
                    else if (a > e)
                    begin
                        add_piece(s, e);
                        placed = 1;
                        add_piece(a, b);
                    end
                    else
                    begin
                        if (a < s)
                            s = a;
                        if (b > e)
                            e = b;
                    end
                end
                if (!placed)
                    add_piece(s, e);
                v.dropped = write_back(sl);
            end
        end
        return v;
    endfunction

    function automatic event_t mk(logic [1:0] op, logic [7:0] tag, int offs, int width);
        event_t ev;
        ev.op = op;
        ev.tag = tag;
        ev.offs = offs;
        ev.width = width[15:0];
        return ev;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_verdicts.insert(expected_verdicts.size(),
                                         predict_verdict(pending_events.pop_front()));
                accepted_events++;
            end
            if ((!s_tvalid || s_tready) && pending_events.size() > 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {pending_events[0].width, pending_events[0].offs,
                            pending_events[0].tag};
                s_tuser <= pending_events[0].op;
            end
            else if (s_tvalid && s_tready)
                s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t got;
        verdict_t exp_v;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.dead = m_tdata[0];
                got.dropped = m_tdata[1];
                if (expected_verdicts.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat dead=%0b dropped=%0b",
                                 got.dead, got.dropped);
                end
                else
                begin
                    exp_v = expected_verdicts.pop_front();
                    checked_verdicts++;
                    dead_seen += got.dead;
                    drop_seen += got.dropped;
                    if (got.dead !== exp_v.dead || got.dropped !== exp_v.dropped)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch at result %0d: dead exp %0b got %0b, dropped exp %0b got %0b",
                                     checked_verdicts, exp_v.dead, got.dead,
                                     exp_v.dropped, got.dropped);
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n
            || hold_cycles > 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("watchdog expired");
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_random(int n);
        int r;
        int base;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            base = $urandom_range(3) * 64 - 96;
            if (r < 2)
                queue_event(mk(CMD_NONE, 8'($urandom), $urandom, $urandom));
            else if (r < 5)
                queue_event(mk(CMD_CLEAR, 8'($urandom), $urandom, $urandom));
            else if (r < 10)
                // wild fields: full offset and width range, any tag
                queue_event(mk(2'($urandom_range(1)), 8'($urandom), $urandom,
                               $urandom));
            else if (r < 70)
                queue_event(mk(CMD_STORE, 8'($urandom_range(9)),
                               base + $urandom_range(127),
                               $urandom_range(16)));
            else
                queue_event(mk(CMD_LOAD, 8'($urandom_range(9)),
                               base + $urandom_range(127),
                               $urandom_range(8)));
        end
    endtask

    task automatic wait_drained();
        while (pending_events.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        errors = 0;
        accepted_events = 0;
        checked_verdicts = 0;
        dead_seen = 0;
        drop_seen = 0;
        quiet_cycles = 0;
        hold_cycles = 0;
        stim_done = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used_q[i] = 0;
            slot_tag_q[i] = '0;
            iv_cnt[i] = 0;
        end
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: dead store, adjacency merge, holes, extremes, odd commands
        queue_event(mk(CMD_STORE, 8'd1, 0, 8));
        queue_event(mk(CMD_STORE, 8'd1, 2, 4));
        queue_event(mk(CMD_STORE, 8'd1, 8, 8));
        queue_event(mk(CMD_STORE, 8'd1, 4, 12));
        queue_event(mk(CMD_LOAD, 8'd1, 6, 2));
        queue_event(mk(CMD_STORE, 8'd1, 6, 2));
        queue_event(mk(CMD_STORE, 8'd1, 0, 0));
        queue_event(mk(CMD_LOAD, 8'd1, 0, 0));
        queue_event(mk(CMD_LOAD, 8'd77, 0, 4));
        queue_event(mk(CMD_STORE, 8'd255, 32'h8000_0000, 16'hffff));
        queue_event(mk(CMD_STORE, 8'd255, 32'h7fff_0000, 16'hffff));
        queue_event(mk(CMD_STORE, 8'd255, 32'h7fff_ffff, 1));
        queue_event(mk(CMD_NONE, 8'd255, -1, 16'hffff));
        for (int i = 2; i < 10; i++)   // fill every slot, then miss
            queue_event(mk(CMD_STORE, i[7:0], 0, 1));
        // overflow of one base: 17 separate intervals
        for (int i = 0; i < 17; i++)
            queue_event(mk(CMD_STORE, 8'd2, 4 * i, 2));
        queue_event(mk(CMD_LOAD, 8'd2, 1, 61));
        queue_event(mk(CMD_CLEAR, 8'd0, 0, 0));
        send_idle_pct = 30;
        recv_idle_pct = 74;
        wait_drained();

        push_random(250);
        // long receiver hold while the sender keeps offering
        hold_cycles = 400;
        wait_drained();

        send_idle_pct = 74;
        recv_idle_pct = 30;
        push_random(250);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(250);
        wait_drained();

        $display("accepted %0d events, checked %0d results (%0d dead, %0d dropped)",
                 accepted_events, checked_verdicts, dead_seen, drop_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
